// File: rtl/ppq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ppq_pkg;

	typedef logic [7:0] chan_t;
	typedef logic [2:0] reg_idx_t;
	typedef logic [8:0] cfg_data_t;

	localparam reg_idx_t REG_MODE    = 3'd0;
	localparam reg_idx_t REG_BW_TH   = 3'd1;
	localparam reg_idx_t REG_GRAY_N  = 3'd2;
	localparam reg_idx_t REG_HUE_N   = 3'd3;
	localparam reg_idx_t REG_SAT_TH  = 3'd4;

	localparam logic [1:0] MODE_BW   = 2'd0;
	localparam logic [1:0] MODE_GRAY = 2'd1;
	localparam logic [1:0] MODE_HUE  = 2'd2;
	localparam logic [1:0] MODE_PASS = 2'd3;

	localparam logic [2:0] SEC_RY = 3'd0;
	localparam logic [2:0] SEC_YG = 3'd1;
	localparam logic [2:0] SEC_GC = 3'd2;
	localparam logic [2:0] SEC_CB = 3'd3;
	localparam logic [2:0] SEC_BM = 3'd4;
	localparam logic [2:0] SEC_MR = 3'd5;

endpackage
`default_nettype wire

// File: rtl/ppq_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ppq_in_if;
	logic valid;
	logic ready;
	ppq_pkg::chan_t red;
	ppq_pkg::chan_t green;
	ppq_pkg::chan_t blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

// File: rtl/ppq_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ppq_out_if;
	logic valid;
	logic ready;
	ppq_pkg::chan_t out_red;
	ppq_pkg::chan_t out_green;
	ppq_pkg::chan_t out_blue;

	modport source (output valid, output out_red, output out_green, output out_blue,
		input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue,
		output ready);
endinterface
`default_nettype wire

// File: rtl/pixel_posterize_quantizer.sv
// Pixel posterizer: converts one RGB pixel per transfer on the input channel
// into one RGB pixel on the output channel, in black and white, gray level
// or saturated hue style, or unchanged, as chosen by the mode register.
// Registers are written through wr_en, wr_index and wr_data, one register
// per clock; the user must write them only while no pixel is in flight, as
// the block does not enforce it. The block accepts a pixel in every cycle
// in which the pipeline advances, so the sustained throughput is one pixel
// per clock. A pixel passes two input stages, a 16-stage divider bank for
// saturation and hue, two stages, a 9-stage divider for the gray level,
// one stage, a 9-stage divider for the output hue, and two stages to build
// the color. The gray index and the hue index have constant divisors and
// come from reciprocal multiplications that run beside the divider banks.
// All stages advance together whenever the output register is empty or its
// pixel is being taken; while the receiver stalls with a pixel waiting, the
// whole pipeline holds and input ready is low, so nothing is lost or repeated.
// Reset empties the pipeline and loads the register defaults: mode black and
// white, thresholds 127, two gray levels and six hues.
`timescale 1ns / 1ps
`default_nettype none
module pixel_posterize_quantizer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire ppq_pkg::reg_idx_t  wr_index,
	input  wire ppq_pkg::cfg_data_t wr_data,
	ppq_in_if.sink                  pixel,
	ppq_out_if.source               poster
);
	import ppq_pkg::*;

	logic [1:0] mode_q;
	logic [7:0] bw_th_q;
	logic [8:0] gray_n_q;
	logic [8:0] hue_n_q;
	logic [7:0] sat_th_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BW;
			bw_th_q <= 8'd127;
			gray_n_q <= 9'd2;
			hue_n_q <= 9'd6;
			sat_th_q <= 8'd127;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MODE:   mode_q <= wr_data[1:0];
				REG_BW_TH:  bw_th_q <= wr_data[7:0];
				REG_GRAY_N: gray_n_q <= wr_data;
				REG_HUE_N:  hue_n_q <= wr_data;
				REG_SAT_TH: sat_th_q <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	logic [8:0] n1;
	logic [8:0] hc;
	assign n1 = ((gray_n_q < 9'd2) ? 9'd2 : gray_n_q) - 9'd1;
	assign hc = (hue_n_q == 9'd0) ? 9'd1 : hue_n_q;

	logic adv;
	logic v_s7;
	assign adv = !v_s7 || poster.ready;
	assign pixel.ready = adv;

	// Stage 1: luma, channel extremes.
	logic [12:0] luma_sum;
	logic [7:0]  mx_c, mn_c;
	assign luma_sum = 13'd11 * 13'(pixel.red) + 13'd16 * 13'(pixel.green)
		+ 13'd5 * 13'(pixel.blue);
	always_comb begin
		mx_c = pixel.red;
		mn_c = pixel.red;
		if (pixel.green > mx_c) mx_c = pixel.green;
		if (pixel.blue > mx_c) mx_c = pixel.blue;
		if (pixel.green < mn_c) mn_c = pixel.green;
		if (pixel.blue < mn_c) mn_c = pixel.blue;
	end

	logic       v_s1;
	logic [1:0] mode_s1;
	logic [7:0] r_s1, g_s1, b_s1, gray_s1, mx_s1, delta_s1;
	logic       bw_s1, rmax_s1, gmax_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= mode_q;
			r_s1 <= pixel.red;
			g_s1 <= pixel.green;
			b_s1 <= pixel.blue;
			gray_s1 <= luma_sum[12:5];
			bw_s1 <= luma_sum[12:5] <= bw_th_q;
			mx_s1 <= mx_c;
			delta_s1 <= mx_c - mn_c;
			rmax_s1 <= pixel.red == mx_c;
			gmax_s1 <= pixel.green == mx_c;
		end
	end

	// Stage 2: numerators and divisors of the first divider bank.
	logic [10:0] hnum;
	always_comb begin
		if (rmax_s1) begin
			if (g_s1 >= b_s1) hnum = 11'(g_s1) - 11'(b_s1);
			else hnum = 11'(delta_s1) * 11'd6 - (11'(b_s1) - 11'(g_s1));
		end else if (gmax_s1) begin
			hnum = 11'(delta_s1) * 11'd2 + 11'(b_s1) - 11'(r_s1);
		end else begin
			hnum = 11'(delta_s1) * 11'd4 + 11'(r_s1) - 11'(g_s1);
		end
	end

	logic        v_s2;
	logic [24:0] d1_num_s2, d2_num_s2, d3_num_s2;
	logic [9:0]  d2_den_s2, d3_den_s2;
	logic [1:0]  mode_s2;
	logic [7:0]  r_s2, g_s2, b_s2;
	logic        bw_s2, dz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d1_num_s2 <= 25'({gray_s1, 1'b0}) * 25'(n1) + 25'd255;
			d2_num_s2 <= 25'(delta_s1) * 25'd510 + 25'(mx_s1);
			d2_den_s2 <= {1'b0, mx_s1, 1'b0};
			d3_num_s2 <= 25'(hnum) * 25'd12000 + 25'(delta_s1);
			d3_den_s2 <= {1'b0, delta_s1, 1'b0};
			mode_s2 <= mode_s1;
			r_s2 <= r_s1;
			g_s2 <= g_s1;
			b_s2 <= b_s1;
			bw_s2 <= bw_s1;
			dz_s2 <= delta_s1 == 8'd0;
		end
	end

	// Gray index: division by 510 as a reciprocal multiplication.
	logic [44:0] gidx_prod;
	logic [8:0]  gidx_c;
	assign gidx_prod = 45'(d1_num_s2) * 45'd526345;
	assign gidx_c = gidx_prod[36:28];

	// First divider bank: saturation, hue in hundredths.
	logic [15:0] q2, q3;
	logic [11:0] p2;
	logic [25:0] p3;

	ppq_div #(.NW(25), .DW(10), .QW(16), .PW(12)) u_div_sat (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.num(d2_num_s2), .den(d2_den_s2),
		.pay_in({mode_s2, dz_s2, gidx_c}),
		.quo(q2), .pay_out(p2)
	);

	ppq_div #(.NW(25), .DW(10), .QW(16), .PW(26)) u_div_hue (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.num(d3_num_s2), .den(d3_den_s2),
		.pay_in({v_s2, r_s2, g_s2, b_s2, bw_s2}),
		.quo(q3), .pay_out(p3)
	);

	// Stage 3: whole degrees of hue, fallback decision.
	logic [28:0] hue_prod;
	assign hue_prod = 29'(q3) * 29'd5243;

	logic       v_s3;
	logic [8:0] hue_s3, gidx_s3;
	logic [1:0] mode_s3;
	logic [7:0] r_s3, g_s3, b_s3;
	logic       bw_s3, ug_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= p3[25];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hue_s3 <= hue_prod[27:19];
			gidx_s3 <= p2[8:0];
			mode_s3 <= p2[11:10];
			r_s3 <= p3[24:17];
			g_s3 <= p3[16:9];
			b_s3 <= p3[8:1];
			bw_s3 <= p3[0];
			ug_s3 <= p2[9] || (q2 <= 16'(sat_th_q));
		end
	end

	// Stage 4: numerators of the second divider bank.
	logic        v_s4;
	logic [19:0] d4_num_s4, d5_num_s4;
	logic [9:0]  d4_den_s4;
	logic [1:0]  mode_s4;
	logic [7:0]  r_s4, g_s4, b_s4;
	logic        bw_s4, ug_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d4_num_s4 <= 20'(gidx_s3) * 20'd510 + 20'(n1);
			d4_den_s4 <= {n1, 1'b0};
			d5_num_s4 <= 20'({hue_s3, 1'b0}) * 20'(hc) + 20'd360;
			mode_s4 <= mode_s3;
			r_s4 <= r_s3;
			g_s4 <= g_s3;
			b_s4 <= b_s3;
			bw_s4 <= bw_s3;
			ug_s4 <= ug_s3;
		end
	end

	// Hue index: division by 720 as a reciprocal multiplication.
	logic [39:0] hidx_prod;
	logic [8:0]  q5_c;
	assign hidx_prod = 40'(d5_num_s4) * 40'd745655;
	assign q5_c = hidx_prod[37:29];

	// Second divider bank: gray level.
	logic [8:0]  q4, q5;
	logic [37:0] p4;

	ppq_div #(.NW(20), .DW(10), .QW(9), .PW(38)) u_div_glev (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.num(d4_num_s4), .den(d4_den_s4),
		.pay_in({v_s4, mode_s4, r_s4, g_s4, b_s4, bw_s4, ug_s4, q5_c}),
		.quo(q4), .pay_out(p4)
	);

	assign q5 = p4[8:0];

	// Stage 5: wrap hue index, numerator of output hue.
	logic [8:0] hidx;
	assign hidx = (q5 == hc) ? 9'd0 : q5;

	logic        v_s5;
	logic [19:0] d6_num_s5;
	logic [9:0]  d6_den_s5;
	logic [35:0] pay_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= p4[37];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d6_num_s5 <= 20'(hidx) * 20'd720 + 20'(hc);
			d6_den_s5 <= {hc, 1'b0};
			pay_s5 <= {p4[36:9], (q4 > 9'd255) ? 8'd255 : q4[7:0]};
		end
	end

	// Output hue divider.
	logic [8:0]  q6;
	logic [36:0] p6;

	ppq_div #(.NW(20), .DW(10), .QW(9), .PW(37)) u_div_ohue (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.num(d6_num_s5), .den(d6_den_s5),
		.pay_in({v_s5, pay_s5}),
		.quo(q6), .pay_out(p6)
	);

	// Stage 6: hue sector and offset within it.
	logic [8:0] oh, sec_base, m_full;
	logic [2:0] sec;
	always_comb begin
		oh = (q6 >= 9'd360) ? q6 - 9'd360 : q6;
		if (oh >= 9'd300) begin
			sec = SEC_MR;
			sec_base = 9'd300;
		end else if (oh >= 9'd240) begin
			sec = SEC_BM;
			sec_base = 9'd240;
		end else if (oh >= 9'd180) begin
			sec = SEC_CB;
			sec_base = 9'd180;
		end else if (oh >= 9'd120) begin
			sec = SEC_GC;
			sec_base = 9'd120;
		end else if (oh >= 9'd60) begin
			sec = SEC_YG;
			sec_base = 9'd60;
		end else begin
			sec = SEC_RY;
			sec_base = 9'd0;
		end
		m_full = oh - sec_base;
	end

	logic        v_s6;
	logic [2:0]  sec_s6;
	logic [5:0]  m_s6;
	logic [35:0] pay_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= p6[36];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sec_s6 <= sec;
			m_s6 <= m_full[5:0];
			pay_s6 <= p6[35:0];
		end
	end

	// Stage 7: color build and mode selection into the output register.
	logic [1:0] mode_f;
	logic [7:0] r_f, g_f, b_f, glev_f;
	logic       bw_f, ug_f;
	assign {mode_f, r_f, g_f, b_f, bw_f, ug_f, glev_f} = pay_s6;

	logic [9:0] up_sum, down_sum;
	logic [7:0] up, down;
	logic [7:0] hr, hg, hb, or_c, og_c, ob_c;
	assign up_sum = 10'd17 * 10'(m_s6) + 10'd2;
	assign down_sum = 10'd17 * (10'd60 - 10'(m_s6)) + 10'd2;
	assign up = up_sum[9:2];
	assign down = down_sum[9:2];

	always_comb begin
		case (sec_s6)
			SEC_RY:  begin hr = 8'd255; hg = up;     hb = 8'd0;   end
			SEC_YG:  begin hr = down;   hg = 8'd255; hb = 8'd0;   end
			SEC_GC:  begin hr = 8'd0;   hg = 8'd255; hb = up;     end
			SEC_CB:  begin hr = 8'd0;   hg = down;   hb = 8'd255; end
			SEC_BM:  begin hr = up;     hg = 8'd0;   hb = 8'd255; end
			default: begin hr = 8'd255; hg = 8'd0;   hb = down;   end
		endcase
		unique case (mode_f)
			MODE_BW: begin
				or_c = bw_f ? 8'd0 : 8'd255;
				og_c = or_c;
				ob_c = or_c;
			end
			MODE_GRAY: begin
				or_c = glev_f;
				og_c = glev_f;
				ob_c = glev_f;
			end
			MODE_HUE: begin
				or_c = ug_f ? glev_f : hr;
				og_c = ug_f ? glev_f : hg;
				ob_c = ug_f ? glev_f : hb;
			end
			default: begin
				or_c = r_f;
				og_c = g_f;
				ob_c = b_f;
			end
		endcase
	end

	logic [7:0] or_s7, og_s7, ob_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			or_s7 <= or_c;
			og_s7 <= og_c;
			ob_s7 <= ob_c;
		end
	end

	assign poster.valid = v_s7;
	assign poster.out_red = or_s7;
	assign poster.out_green = og_s7;
	assign poster.out_blue = ob_s7;
endmodule
`default_nettype wire

// File: rtl/ppq_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ppq_div #(
	parameter int NW = 25,
	parameter int DW = 10,
	parameter int QW = 16,
	parameter int PW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [PW-1:0] pay_in,
	output logic      [QW-1:0] quo,
	output logic      [PW-1:0] pay_out
);
	localparam int W = NW + DW + QW;

	logic [NW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic [PW-1:0] pay_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		localparam int SH = QW - 1 - i;
		logic [NW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] quo_in;
		logic [PW-1:0] pay_stage_in;
		logic [W-1:0]  trial;
		logic          take;

		if (i == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
			assign pay_stage_in = pay_in;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
			assign pay_stage_in = pay_s[i-1];
		end

		always_comb begin
			trial = W'(den_in) << SH;
			take = W'(rem_in) >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rem_s[i] <= '0;
				den_s[i] <= '0;
				quo_s[i] <= '0;
				pay_s[i] <= '0;
			end else if (en) begin
				rem_s[i] <= take ? NW'(W'(rem_in) - trial) : rem_in;
				den_s[i] <= den_in;
				quo_s[i] <= quo_in | (QW'(take) << SH);
				pay_s[i] <= pay_stage_in;
			end
		end
	end

	assign quo = quo_s[QW-1];
	assign pay_out = pay_s[QW-1];
endmodule
`default_nettype wire

// File: tb/sv/tb_ppq_if.sv
`timescale 1ns / 1ps
interface tb_ppq_cfg_if;
	logic               wr_en;
	ppq_pkg::reg_idx_t  wr_index;
	ppq_pkg::cfg_data_t wr_data;
endinterface

// File: tb/sv/ppq_checker.sv
`timescale 1ns / 1ps
module ppq_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               wr_en,
	input wire ppq_pkg::reg_idx_t  wr_index,
	input wire ppq_pkg::cfg_data_t wr_data,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire ppq_pkg::chan_t     red,
	input wire ppq_pkg::chan_t     green,
	input wire ppq_pkg::chan_t     blue,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire ppq_pkg::chan_t     out_red,
	input wire ppq_pkg::chan_t     out_green,
	input wire ppq_pkg::chan_t     out_blue,
	output int                     fail_count,
	output int                     pending
);
	import ppq_pkg::*;

	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
	} pixel_t;

	logic [1:0] cur_mode;
	logic [7:0] cur_bw_th;
	logic [8:0] cur_gray_n;
	logic [8:0] cur_hue_n;
	logic [7:0] cur_sat_th;
	pixel_t     expected_pixels[$];

	function automatic int unsigned gray_level(int unsigned gray);
		int unsigned n1;
		int unsigned idx;
		int unsigned v;
		n1 = (cur_gray_n < 2 ? 2 : cur_gray_n) - 1;
		idx = (2 * gray * n1 + 255) / 510;
		v = (2 * idx * 255 + n1) / (2 * n1);
		return v > 255 ? 255 : v;
	endfunction

	function automatic pixel_t saturated_color(int unsigned h);
		int unsigned up;
		int unsigned down;
		pixel_t p;
		up = (17 * (h % 60) + 2) / 4;
		down = (17 * (60 - h % 60) + 2) / 4;
		case ((h % 360) / 60)
			SEC_RY: p = '{8'd255, up[7:0], 8'd0};
			SEC_YG: p = '{down[7:0], 8'd255, 8'd0};
			SEC_GC: p = '{8'd0, 8'd255, up[7:0]};
			SEC_CB: p = '{8'd0, down[7:0], 8'd255};
			SEC_BM: p = '{up[7:0], 8'd0, 8'd255};
			default: p = '{8'd255, 8'd0, down[7:0]};
		endcase
		return p;
	endfunction

	function automatic pixel_t posterize(int unsigned r, int unsigned g, int unsigned b);
		int unsigned gray, mx, mn, delta, sat, num, hue, hc, idx, oh;
		pixel_t p;
		gray = (11 * r + 16 * g + 5 * b) >> 5;
		p = '{r[7:0], g[7:0], b[7:0]};
		if (cur_mode == MODE_BW) begin
			p = (gray <= cur_bw_th) ? '0 : '1;
		end else if (cur_mode == MODE_GRAY) begin
			gray = gray_level(gray);
			p = '{gray[7:0], gray[7:0], gray[7:0]};
		end else if (cur_mode == MODE_HUE) begin
			mx = r;
			mn = r;
			if (g > mx) mx = g;
			if (b > mx) mx = b;
			if (g < mn) mn = g;
			if (b < mn) mn = b;
			delta = mx - mn;
			sat = (delta == 0) ? 0 : (2 * delta * 255 + mx) / (2 * mx);
			if (delta == 0 || sat <= cur_sat_th) begin
				gray = gray_level(gray);
				p = '{gray[7:0], gray[7:0], gray[7:0]};
			end else begin
				if (r == mx)
					num = (g >= b) ? (g - b) : (6 * delta - (b - g));
				else if (g == mx)
					num = 2 * delta + b - r;
				else
					num = 4 * delta + r - g;
				hue = ((12000 * num + delta) / (2 * delta)) / 100;
				hc = (cur_hue_n == 0) ? 1 : cur_hue_n;
				idx = ((2 * hue * hc + 360) / 720) % hc;
				oh = ((2 * idx * 360 + hc) / (2 * hc)) % 360;
				p = saturated_color(oh);
			end
		end
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			cur_mode <= MODE_BW;
			cur_bw_th <= 8'd127;
			cur_gray_n <= 9'd2;
			cur_hue_n <= 9'd6;
			cur_sat_th <= 8'd127;
			fail_count <= 0;
			expected_pixels.delete();
			pending <= 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_MODE:   cur_mode <= wr_data[1:0];
					REG_BW_TH:  cur_bw_th <= wr_data[7:0];
					REG_GRAY_N: cur_gray_n <= wr_data;
					REG_HUE_N:  cur_hue_n <= wr_data;
					REG_SAT_TH: cur_sat_th <= wr_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_pixels.push_back(posterize(red, green, blue));
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected output pixel %0d %0d %0d",
							out_red, out_green, out_blue);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_pixels.pop_front();
					if (want !== {out_red, out_green, out_blue}) begin
						if (fail_count < 10)
							$display("pixel mismatch: expected %0d %0d %0d, got %0d %0d %0d",
								want.r, want.g, want.b, out_red, out_green, out_blue);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= expected_pixels.size();
		end
	end
endmodule

// File: tb/sv/tb_pixel_posterize_quantizer.sv
`timescale 1ns / 1ps
module tb_pixel_posterize_quantizer;
	import ppq_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;

	tb_ppq_cfg_if cfg ();
	ppq_in_if     pixel ();
	ppq_out_if    poster ();

	always #6 clk = ~clk;

	pixel_posterize_quantizer u_top (
		.clk(clk), .arst_n(arst_n), .wr_en(cfg.wr_en), .wr_index(cfg.wr_index),
		.wr_data(cfg.wr_data), .pixel(pixel.sink), .poster(poster.source)
	);

	ppq_checker u_checker (
		.clk(clk), .arst_n(arst_n), .wr_en(cfg.wr_en), .wr_index(cfg.wr_index),
		.wr_data(cfg.wr_data), .in_valid(pixel.valid), .in_ready(pixel.ready),
		.red(pixel.red), .green(pixel.green), .blue(pixel.blue),
		.out_valid(poster.valid), .out_ready(poster.ready),
		.out_red(poster.out_red), .out_green(poster.out_green),
		.out_blue(poster.out_blue), .fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		poster.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic write_reg(reg_idx_t idx, int unsigned value);
		cfg.wr_en <= 1'b1;
		cfg.wr_index <= idx;
		cfg.wr_data <= value[8:0];
		@(posedge clk);
	endtask

	task automatic send_pixel(int unsigned r, int unsigned g, int unsigned b);
		while ($urandom_range(99) < send_idle_pct) begin
			pixel.valid <= 1'b0;
			@(posedge clk);
		end
		pixel.valid <= 1'b1;
		pixel.red <= r[7:0];
		pixel.green <= g[7:0];
		pixel.blue <= b[7:0];
		do @(posedge clk); while (!pixel.ready);
	endtask

	task automatic drain();
		pixel.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic random_pixel();
		int unsigned base;
		case ($urandom_range(3))
			0: send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
			1: begin
				base = $urandom_range(255);
				send_pixel(base, base, base);
			end
			2: send_pixel($urandom_range(1) * 255, $urandom_range(255), $urandom_range(1) * 255);
			default: send_pixel($urandom_range(255), $urandom_range(60), $urandom_range(255));
		endcase
	endtask

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int unsigned settings[10][5] = '{
			'{MODE_BW, 0, 2, 6, 127},
			'{MODE_BW, 255, 2, 6, 127},
			'{MODE_GRAY, 127, 2, 1, 0},
			'{MODE_GRAY, 127, 256, 360, 255},
			'{MODE_GRAY, 30, 1, 0, 30},
			'{MODE_HUE, 127, 5, 6, 127},
			'{MODE_HUE, 0, 256, 360, 0},
			'{MODE_HUE, 200, 511, 0, 255},
			'{MODE_HUE, 90, 17, 511, 10},
			'{MODE_PASS, 127, 2, 6, 127}
		};
		int unsigned idle_plan[4][2] = '{'{0, 0}, '{65, 0}, '{0, 65}, '{29, 29}};
		cfg.wr_en = 1'b0;
		cfg.wr_index = REG_MODE;
		cfg.wr_data = '0;
		pixel.valid = 1'b0;
		pixel.red = '0;
		pixel.green = '0;
		pixel.blue = '0;
		poster.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pixel(0, 0, 0);
		send_pixel(255, 255, 255);
		send_pixel(255, 0, 0);
		send_pixel(0, 255, 0);
		send_pixel(0, 0, 255);
		send_pixel(128, 128, 128);
		drain();
		for (int s = 0; s < 10; s++) begin
			for (int k = 0; k < 5; k++)
				write_reg(reg_idx_t'(k), settings[s][k]);
			cfg.wr_en <= 1'b0;
			send_pixel(0, 0, 0);
			send_pixel(255, 255, 255);
			send_pixel(255, 0, 255);
			send_pixel(200, 200, 10);
			send_pixel(10, 200, 200);
			send_pixel(3, 0, 0);
			send_pixel(255, 128, 128);
			drain();
		end
		for (int s = 0; s < 10; s++) begin
			for (int k = 0; k < 5; k++)
				write_reg(reg_idx_t'(k), settings[s][k]);
			cfg.wr_en <= 1'b0;
			for (int p = 0; p < 4; p++) begin
				send_idle_pct = idle_plan[p][0];
				recv_stall_pct = idle_plan[p][1];
				repeat (12) random_pixel();
			end
			recv_stall_pct = 0;
			drain();
		end

		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
